// ===== src/arlt_pkg.sv =====
// ----------------------------------------------------------------------------
// arlt_pkg
// Shared types, codes and keyword tables for the AT response link tracker.
// ----------------------------------------------------------------------------
package arlt_pkg;

  // Request opcodes
  typedef enum logic {
    OP_BYTE    = 1'b0,
    OP_MEASURE = 1'b1
  } op_t;

  // Commands to transmit
  typedef enum logic [3:0] {
    CMD_NONE     = 4'd0,
    CMD_AT       = 4'd1,
    CMD_MUX      = 4'd2,
    CMD_SERVER   = 4'd3,
    CMD_SHOW_IP  = 4'd4,
    CMD_SEND_LEN = 4'd5,
    CMD_PAGE     = 4'd6,
    CMD_CLOSE    = 4'd7,
    CMD_START    = 4'd8
  } cmd_t;

  // Protocol states
  typedef enum logic [3:0] {
    ST_WAIT_READY  = 4'd0,
    ST_WAIT_GOTIP  = 4'd1,
    ST_WAIT_OK     = 4'd2,
    ST_MUX         = 4'd3,
    ST_SERVER      = 4'd4,
    ST_SHOW_IP     = 4'd5,
    ST_WAIT_HDR    = 4'd6,
    ST_CHANNEL     = 4'd7,
    ST_LENGTH      = 4'd8,
    ST_PAYLOAD     = 4'd9,
    ST_WAIT_PROMPT = 4'd10,
    ST_WAIT_SENDOK = 4'd11,
    ST_WAIT_CONN   = 4'd12
  } st_t;

  // Keywords
  typedef enum logic [3:0] {
    KW_READY  = 4'd0,
    KW_GOTIP  = 4'd1,
    KW_OK     = 4'd2,
    KW_ERR    = 4'd3,
    KW_SENDOK = 4'd4,
    KW_PROMPT = 4'd5,
    KW_IPD    = 4'd6,
    KW_COMMA  = 4'd7,
    KW_COLON  = 4'd8
  } kw_t;

  localparam int KW_MAX_LEN = 13;

  localparam logic [13:0] LEN_SAT   = 14'd9999;
  localparam logic [7:0]  CHAR_ZERO = 8'h30;
  localparam logic [7:0]  CHAR_NINE = 8'h39;

  typedef logic [0:KW_MAX_LEN-1][7:0] kw_text_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] pos;
  } kw_res_t;

  // Keyword text, first character in element 0
  function automatic kw_text_t kw_text(input kw_t id);
    kw_text_t t;
    t = '0;
    case (id)
      KW_READY:  t = {"ready\r\n", 48'h0};
      KW_GOTIP:  t = "WIFI GOT IP\r\n";
      KW_OK:     t = {"OK\r\n", 72'h0};
      KW_ERR:    t = {"ERROR", 64'h0};
      KW_SENDOK: t = {"SEND OK\r\n", 32'h0};
      KW_PROMPT: t = {">", 96'h0};
      KW_IPD:    t = {"+IPD,", 64'h0};
      KW_COMMA:  t = {",", 96'h0};
      KW_COLON:  t = {":", 96'h0};
      default:   t = '0;
    endcase
    return t;
  endfunction

  function automatic logic [3:0] kw_len(input kw_t id);
    logic [3:0] n;
    n = 4'd1;
    case (id)
      KW_READY:  n = 4'd7;
      KW_GOTIP:  n = 4'd13;
      KW_OK:     n = 4'd4;
      KW_ERR:    n = 4'd5;
      KW_SENDOK: n = 4'd9;
      KW_IPD:    n = 4'd5;
      default:   n = 4'd1;
    endcase
    return n;
  endfunction

  // One step of a naive keyword match: a mismatch drops back to zero
  function automatic kw_res_t kw_step(input logic [3:0] pos, input kw_t id,
                                      input logic [7:0] c);
    kw_res_t    r;
    kw_text_t   t;
    logic [3:0] n;
    logic [3:0] p;
    t = kw_text(id);
    n = kw_len(id);
    p = 4'd0;
    if (pos < n) begin
      if (c == t[pos]) begin
        p = pos + 4'd1;
      end
    end
    r.hit = (p == n);
    r.pos = r.hit ? 4'd0 : p;
    return r;
  endfunction

endpackage

// ===== src/arlt_if.sv =====
// ----------------------------------------------------------------------------
// arlt channel interfaces
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface arlt_req_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] rx_byte;

  modport source(output valid, output opcode, output rx_byte, input ready);
  modport sink(input valid, input opcode, input rx_byte, output ready);
endinterface

interface arlt_rsp_if;
  logic        valid;
  logic        ready;
  logic [3:0]  send_command;
  logic [15:0] channel_text;
  logic [1:0]  channel_chars;
  logic [13:0] payload_length;
  logic        payload_valid;
  logic [7:0]  payload_byte;
  logic [5:0]  payload_index;
  logic [7:0]  echo_byte;
  logic [3:0]  link_state;

  modport source(output valid, output send_command, output channel_text,
                 output channel_chars, output payload_length, output payload_valid,
                 output payload_byte, output payload_index, output echo_byte,
                 output link_state, input ready);
  modport sink(input valid, input send_command, input channel_text,
               input channel_chars, input payload_length, input payload_valid,
               input payload_byte, input payload_index, input echo_byte,
               input link_state, output ready);
endinterface

// ===== src/at_response_link_tracker.sv =====
// Path: an accepted request is held in the request register, then its response in the response register.
// Throughput: one request per cycle; the whole step is one pass of logic between
// the request register and the response register, and both stages hold on a stall.
// Reset (rst, synchronous): protocol state goes to wait got-ip, match positions,
// counters, channel and length stores clear, both pipeline stages empty.
// ----------------------------------------------------------------------------
// at_response_link_tracker
// Tracks modem responses on the AT text link and names the next command.
// ----------------------------------------------------------------------------
module at_response_link_tracker
  import arlt_pkg::*;
#(
  parameter int PAYLOAD_KEEP      = 40,
  parameter int CHANNEL_CHARS_MAX = 2,
  parameter int LENGTH_DIGITS_MAX = 4
) (
  input  logic       clk,
  input  logic       rst,
  arlt_req_if.sink   req,
  arlt_rsp_if.source rsp
);

  localparam int          HELD_INT = (CHANNEL_CHARS_MAX < 2) ? CHANNEL_CHARS_MAX : 2;
  localparam logic [1:0]  HELD     = 2'(HELD_INT);
  localparam logic [2:0]  LEN_DIG  = 3'(LENGTH_DIGITS_MAX);
  localparam logic [13:0] KEEP     = 14'(PAYLOAD_KEEP);

  typedef struct packed {
    cmd_t        cmd;
    logic [15:0] chan;
    logic [1:0]  chan_cnt;
    logic [13:0] len;
    logic        pvalid;
    logic [7:0]  pbyte;
    logic [5:0]  pidx;
    logic [7:0]  echo;
    st_t         st;
  } rsp_t;

  // Request register
  logic       s1_valid;
  op_t        s1_op;
  logic [7:0] s1_byte;

  // Response register
  logic rsp_valid;
  rsp_t rsp_q;

  // Tracker state
  st_t         state, state_next;
  logic [3:0]  match_pos, match_pos_next;
  logic [3:0]  err_pos, err_pos_next;
  logic [13:0] field_cnt, field_cnt_next;
  logic [15:0] chan, chan_next;
  logic [1:0]  chan_cnt, chan_cnt_next;
  logic [2:0]  len_digits, len_digits_next;
  logic [13:0] len_val, len_val_next;

  logic s2_load;
  logic s1_load;
  rsp_t rsp_next;

  // Pipeline handshake
  assign s2_load   = s1_valid && (!rsp_valid || rsp.ready);
  assign s1_load   = !s1_valid || s2_load;
  assign req.ready = s1_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= req.valid;
    end
    if (s1_load && req.valid) begin
      s1_op   <= op_t'(req.opcode);
      s1_byte <= req.rx_byte;
    end
  end

  // Step logic
  always_comb begin
    kw_res_t     km;
    kw_res_t     ke;
    logic [3:0]  digit;
    logic [16:0] prod;
    logic [13:0] fc;

    state_next      = state;
    match_pos_next  = match_pos;
    err_pos_next    = err_pos;
    field_cnt_next  = field_cnt;
    chan_next       = chan;
    chan_cnt_next   = chan_cnt;
    len_digits_next = len_digits;
    len_val_next    = len_val;
    rsp_next        = '0;
    rsp_next.cmd    = CMD_NONE;

    km    = '0;
    ke    = '0;
    digit = 4'd0;
    prod  = '0;
    fc    = field_cnt;

    if (s1_op == OP_MEASURE) begin
      rsp_next.cmd = CMD_START;
      state_next   = ST_WAIT_CONN;
    end else begin
      rsp_next.echo = s1_byte;
      unique case (state)
        ST_WAIT_READY, ST_WAIT_GOTIP: begin
          km = kw_step(match_pos, (state == ST_WAIT_READY) ? KW_READY : KW_GOTIP,
                       s1_byte);
          match_pos_next = km.pos;
          if (km.hit) begin
            state_next   = ST_WAIT_OK;
            rsp_next.cmd = CMD_AT;
          end
        end
        ST_WAIT_OK, ST_MUX, ST_SERVER, ST_SHOW_IP: begin
          km = kw_step(match_pos, KW_OK, s1_byte);
          match_pos_next = km.pos;
          if (km.hit) begin
            unique case (state)
              ST_WAIT_OK: begin
                rsp_next.cmd = CMD_MUX;
                state_next   = ST_MUX;
              end
              ST_MUX: begin
                rsp_next.cmd = CMD_SERVER;
                state_next   = ST_SERVER;
              end
              ST_SERVER: begin
                rsp_next.cmd = CMD_SHOW_IP;
                state_next   = ST_SHOW_IP;
              end
              default: begin
                state_next = ST_WAIT_HDR;
              end
            endcase
          end
        end
        ST_WAIT_HDR: begin
          km = kw_step(match_pos, KW_IPD, s1_byte);
          match_pos_next = km.pos;
          if (km.hit) begin
            state_next     = ST_CHANNEL;
            field_cnt_next = '0;
            chan_next      = '0;
            chan_cnt_next  = '0;
          end
        end
        ST_CHANNEL: begin
          km = kw_step(match_pos, KW_COMMA, s1_byte);
          match_pos_next = km.pos;
          if (km.hit) begin
            state_next      = ST_LENGTH;
            len_digits_next = '0;
            len_val_next    = '0;
          end else if (chan_cnt < HELD) begin
            // first character lands in the high byte
            chan_next     = (chan_cnt == 2'd0) ? (chan | {s1_byte, 8'h00})
                                               : (chan | {8'h00, s1_byte});
            chan_cnt_next = chan_cnt + 2'd1;
          end
        end
        ST_LENGTH: begin
          km = kw_step(match_pos, KW_COLON, s1_byte);
          match_pos_next = km.pos;
          if (km.hit) begin
            state_next     = ST_PAYLOAD;
            field_cnt_next = '0;
          end else if (len_digits < LEN_DIG) begin
            // non-digits count as zero; value saturates
            if (s1_byte >= CHAR_ZERO && s1_byte <= CHAR_NINE) begin
              digit = 4'(s1_byte - CHAR_ZERO);
            end
            prod = {len_val, 3'b000} + {2'b00, len_val, 1'b0} + {13'd0, digit};
            len_val_next    = (prod > {3'b000, LEN_SAT}) ? LEN_SAT : prod[13:0];
            len_digits_next = len_digits + 3'd1;
          end
        end
        ST_PAYLOAD: begin
          if (field_cnt < KEEP) begin
            rsp_next.pvalid = 1'b1;
            rsp_next.pbyte  = s1_byte;
            rsp_next.pidx   = field_cnt[5:0];
          end
          if (field_cnt < len_val) begin
            fc = field_cnt + 14'd1;
          end
          field_cnt_next = fc;
          if (fc >= len_val) begin
            len_val_next   = '0;
            field_cnt_next = '0;
            state_next     = ST_WAIT_PROMPT;
            rsp_next.cmd   = CMD_SEND_LEN;
          end
        end
        ST_WAIT_PROMPT: begin
          km = kw_step(match_pos, KW_PROMPT, s1_byte);
          match_pos_next = km.pos;
          if (km.hit) begin
            state_next   = ST_WAIT_SENDOK;
            rsp_next.cmd = CMD_PAGE;
          end
        end
        ST_WAIT_SENDOK: begin
          km = kw_step(match_pos, KW_SENDOK, s1_byte);
          match_pos_next = km.pos;
          if (km.hit) begin
            state_next      = ST_WAIT_HDR;
            rsp_next.cmd    = CMD_CLOSE;
            chan_next       = '0;
            chan_cnt_next   = '0;
            len_val_next    = '0;
            len_digits_next = '0;
          end
        end
        ST_WAIT_CONN: begin
          // OK and ERROR are watched side by side
          km = kw_step(match_pos, KW_OK, s1_byte);
          ke = kw_step(err_pos, KW_ERR, s1_byte);
          match_pos_next = km.pos;
          err_pos_next   = ke.pos;
          if (km.hit) begin
            field_cnt_next = '0;
            state_next     = ST_WAIT_HDR;
            chan_next      = {CHAR_ZERO, 8'h00};
            chan_cnt_next  = 2'd1;
            rsp_next.cmd   = CMD_CLOSE;
          end
          if (ke.hit) begin
            field_cnt_next = '0;
            state_next     = ST_WAIT_HDR;
          end
        end
        default: begin
          // unused codes only echo
        end
      endcase
    end

    rsp_next.chan     = chan_next;
    rsp_next.chan_cnt = chan_cnt_next;
    rsp_next.len      = len_val_next;
    rsp_next.st       = state_next;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_WAIT_GOTIP;
      match_pos  <= '0;
      err_pos    <= '0;
      field_cnt  <= '0;
      chan       <= '0;
      chan_cnt   <= '0;
      len_digits <= '0;
      len_val    <= '0;
    end else if (s2_load) begin
      state      <= state_next;
      match_pos  <= match_pos_next;
      err_pos    <= err_pos_next;
      field_cnt  <= field_cnt_next;
      chan       <= chan_next;
      chan_cnt   <= chan_cnt_next;
      len_digits <= len_digits_next;
      len_val    <= len_val_next;
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s2_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
    if (s2_load) begin
      rsp_q <= rsp_next;
    end
  end

  assign rsp.valid          = rsp_valid;
  assign rsp.send_command   = rsp_q.cmd;
  assign rsp.channel_text   = rsp_q.chan;
  assign rsp.channel_chars  = rsp_q.chan_cnt;
  assign rsp.payload_length = rsp_q.len;
  assign rsp.payload_valid  = rsp_q.pvalid;
  assign rsp.payload_byte   = rsp_q.pbyte;
  assign rsp.payload_index  = rsp_q.pidx;
  assign rsp.echo_byte      = rsp_q.echo;
  assign rsp.link_state     = rsp_q.st;

  // Checks
  a_measure_start: assert property (@(posedge clk) disable iff (rst)
    (s2_load && s1_op == OP_MEASURE) |=>
      (rsp_q.cmd == CMD_START && rsp_q.st == ST_WAIT_CONN))
    else $error("measurement event did not produce start command");

  a_payload_state: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_q.pvalid) |->
      (rsp_q.st == ST_PAYLOAD || rsp_q.st == ST_WAIT_PROMPT))
    else $error("payload capture outside payload phase");

  a_chan_cnt: assert property (@(posedge clk) disable iff (rst)
    chan_cnt <= HELD)
    else $error("channel count beyond held characters");

  a_len_sat: assert property (@(posedge clk) disable iff (rst)
    len_val <= LEN_SAT)
    else $error("payload length above saturation");

  a_field_cnt: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PAYLOAD) |-> (field_cnt < len_val || field_cnt == 14'd0))
    else $error("payload counter passed length");

endmodule

// ===== verif/at_response_link_tracker_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// at_response_link_tracker_tb
// Drives modem byte streams and measurement events into the link tracker and
// checks every response against a cycle-free model of the protocol state
// machine. Stimulus follows the command flow (boot, header, payload, prompt,
// send-ok, reconnect) with broken keywords, stray bytes and early events mixed
// in. Both handshake sides idle at random; three idling phases are run.
// ----------------------------------------------------------------------------
module at_response_link_tracker_tb;
  import arlt_pkg::*;

  localparam int PAYLOAD_KEEP      = 40;
  localparam int CHANNEL_CHARS_MAX = 2;
  localparam int LENGTH_DIGITS_MAX = 4;
  localparam int CHAN_HELD   = (CHANNEL_CHARS_MAX < 2) ? CHANNEL_CHARS_MAX : 2;
  localparam int CYCLE_LIMIT = 200000;
  localparam int GEN_COPY    = 0;
  localparam int CHECK_COPY  = 1;

  // Tracker state as the model keeps it
  typedef struct packed {
    st_t         state;
    logic [3:0]  pos;
    logic [3:0]  err_pos;
    logic [13:0] count;
    logic [15:0] chan;
    logic [1:0]  nchan;
    logic [2:0]  ndig;
    logic [13:0] len;
  } link_model_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [15:0] chan;
    logic [1:0]  nchan;
    logic [13:0] len;
    logic        pvalid;
    logic [7:0]  pbyte;
    logic [5:0]  pidx;
    logic [7:0]  echo;
    st_t         state;
  } link_rsp_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
  } link_req_t;

  logic clk = 1'b0;
  logic rst;

  arlt_req_if req_ch();
  arlt_rsp_if rsp_ch();

  at_response_link_tracker #(
    .PAYLOAD_KEEP     (PAYLOAD_KEEP),
    .CHANNEL_CHARS_MAX(CHANNEL_CHARS_MAX),
    .LENGTH_DIGITS_MAX(LENGTH_DIGITS_MAX)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // One copy of the tracker state follows generation, the other follows acceptance
  link_model_t link_copy [2];
  link_req_t   pending_requests[$];
  link_rsp_t   predicted_replies[$];
  link_req_t   next_request;
  int          gen_count;
  int          mismatches;
  int          cycle_count;
  int          send_idle_pct;
  int          recv_idle_pct;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic link_model_t link_reset_value();
    link_model_t m;
    m = '0;
    m.state = ST_WAIT_GOTIP;
    return m;
  endfunction

  function automatic string keyword_text(input kw_t id);
    case (id)
      KW_READY:  return "ready\r\n";
      KW_GOTIP:  return "WIFI GOT IP\r\n";
      KW_OK:     return "OK\r\n";
      KW_ERR:    return "ERROR";
      KW_SENDOK: return "SEND OK\r\n";
      KW_PROMPT: return ">";
      KW_IPD:    return "+IPD,";
      KW_COMMA:  return ",";
      default:   return ":";
    endcase
  endfunction

  // Naive keyword match: returns {hit, next position}; a mismatch restarts at zero
  function automatic logic [4:0] keyword_advance(input logic [3:0] pos, input kw_t id,
                                                 input logic [7:0] c);
    string      s;
    int         n;
    logic [3:0] p;
    s = keyword_text(id);
    n = s.len();
    p = 4'd0;
    if (int'(pos) < n) begin
      if (c == s[pos]) p = pos + 4'd1;
    end
    if (int'(p) == n) return {1'b1, 4'd0};
    return {1'b0, p};
  endfunction

  // Advances one copy of the tracker by one request and returns its response
  function automatic link_rsp_t advance_link(input int which, input op_t op,
                                             input logic [7:0] c);
    link_model_t m;
    link_rsp_t   r;
    logic [4:0]  k;
    logic [4:0]  ke;
    int unsigned d;
    int unsigned v;
    m = link_copy[which];
    r = '0;
    r.cmd = CMD_NONE;
    if (op == OP_MEASURE) begin
      r.cmd = CMD_START;
      m.state = ST_WAIT_CONN;
    end else begin
      r.echo = c;
      case (m.state)
        ST_WAIT_READY, ST_WAIT_GOTIP: begin
          k = keyword_advance(m.pos, (m.state == ST_WAIT_READY) ? KW_READY : KW_GOTIP, c);
          m.pos = k[3:0];
          if (k[4]) begin
            m.state = ST_WAIT_OK;
            r.cmd = CMD_AT;
          end
        end
        ST_WAIT_OK, ST_MUX, ST_SERVER: begin
          k = keyword_advance(m.pos, KW_OK, c);
          m.pos = k[3:0];
          // the state code doubles as the command that follows its OK
          if (k[4]) begin
            r.cmd = cmd_t'(m.state);
            m.state = st_t'(m.state + 4'd1);
          end
        end
        ST_SHOW_IP: begin
          k = keyword_advance(m.pos, KW_OK, c);
          m.pos = k[3:0];
          if (k[4]) m.state = ST_WAIT_HDR;
        end
        ST_WAIT_HDR: begin
          k = keyword_advance(m.pos, KW_IPD, c);
          m.pos = k[3:0];
          if (k[4]) begin
            m.state = ST_CHANNEL;
            m.count = '0;
            m.chan = '0;
            m.nchan = '0;
          end
        end
        ST_CHANNEL: begin
          k = keyword_advance(m.pos, KW_COMMA, c);
          m.pos = k[3:0];
          if (k[4]) begin
            m.state = ST_LENGTH;
            m.ndig = '0;
            m.len = '0;
          end else if (int'(m.nchan) < CHAN_HELD) begin
            // first character lands in the high byte, extras are dropped
            if (m.nchan == 2'd0) m.chan[15:8] = c;
            else m.chan[7:0] = m.chan[7:0] | c;
            m.nchan = m.nchan + 2'd1;
          end
        end
        ST_LENGTH: begin
          k = keyword_advance(m.pos, KW_COLON, c);
          m.pos = k[3:0];
          if (k[4]) begin
            m.state = ST_PAYLOAD;
            m.count = '0;
          end else if (int'(m.ndig) < LENGTH_DIGITS_MAX) begin
            // non-digits still use a slot, as a zero
            d = 0;
            if (c >= CHAR_ZERO && c <= CHAR_NINE) d = c - CHAR_ZERO;
            v = m.len * 10 + d;
            if (v > LEN_SAT) v = LEN_SAT;
            m.len = v[13:0];
            m.ndig = m.ndig + 3'd1;
          end
        end
        ST_PAYLOAD: begin
          if (int'(m.count) < PAYLOAD_KEEP) begin
            r.pvalid = 1'b1;
            r.pbyte = c;
            r.pidx = m.count[5:0];
          end
          if (m.count < m.len) m.count = m.count + 14'd1;
          // a zero length still consumes one byte
          if (m.count >= m.len) begin
            m.len = '0;
            m.count = '0;
            m.state = ST_WAIT_PROMPT;
            r.cmd = CMD_SEND_LEN;
          end
        end
        ST_WAIT_PROMPT: begin
          k = keyword_advance(m.pos, KW_PROMPT, c);
          m.pos = k[3:0];
          if (k[4]) begin
            m.state = ST_WAIT_SENDOK;
            r.cmd = CMD_PAGE;
          end
        end
        ST_WAIT_SENDOK: begin
          k = keyword_advance(m.pos, KW_SENDOK, c);
          m.pos = k[3:0];
          if (k[4]) begin
            m.state = ST_WAIT_HDR;
            r.cmd = CMD_CLOSE;
            m.chan = '0;
            m.nchan = '0;
            m.len = '0;
            m.ndig = '0;
          end
        end
        ST_WAIT_CONN: begin
          // OK and ERROR are tracked side by side
          k = keyword_advance(m.pos, KW_OK, c);
          ke = keyword_advance(m.err_pos, KW_ERR, c);
          m.pos = k[3:0];
          m.err_pos = ke[3:0];
          if (k[4]) begin
            m.count = '0;
            m.state = ST_WAIT_HDR;
            m.chan = {CHAR_ZERO, 8'h00};
            m.nchan = 2'd1;
            r.cmd = CMD_CLOSE;
          end
          if (ke[4]) begin
            m.count = '0;
            m.state = ST_WAIT_HDR;
          end
        end
        default: ;
      endcase
    end
    r.chan = m.chan;
    r.nchan = m.nchan;
    r.len = m.len;
    r.state = m.state;
    link_copy[which] = m;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Request generation
  // ---------------------------------------------------------------------------
  task automatic push_request(input op_t op, input logic [7:0] c);
    link_req_t item;
    item.op = op;
    item.data = c;
    void'(advance_link(GEN_COPY, op, c));
    pending_requests.push_back(item);
    gen_count++;
  endtask

  task automatic push_byte(input logic [7:0] c);
    push_request(OP_BYTE, c);
  endtask

  task automatic push_measure();
    push_request(OP_MEASURE, 8'($urandom_range(255)));
  endtask

  task automatic push_prefix(input string s, input int n);
    for (int i = 0; i < n; i++) push_byte(s[i]);
  endtask

  task automatic push_text(input string s);
    push_prefix(s, s.len());
  endtask

  task automatic push_noise(input int n);
    for (int i = 0; i < n; i++) push_byte(8'($urandom_range(255)));
  endtask

  // Start a keyword and cut it off with an event or a stray byte
  task automatic break_keyword(input string s);
    push_prefix(s, $urandom_range(s.len() - 1, 1));
    if ($urandom_range(1) == 0) push_measure();
    else push_noise(1);
  endtask

  // One protocol step's worth of requests, chosen from the generator's state
  task automatic gen_chunk();
    int unsigned pick;
    int unsigned sel;
    string       digits;
    link_model_t g;
    pick = $urandom_range(99);
    g = link_copy[GEN_COPY];
    case (g.state)
      ST_WAIT_READY, ST_WAIT_GOTIP: begin
        if (pick < 80) push_text(keyword_text(KW_GOTIP));
        else break_keyword(keyword_text(KW_GOTIP));
      end
      ST_WAIT_OK, ST_MUX, ST_SERVER, ST_SHOW_IP: begin
        if (pick < 75) push_text("OK\r\n");
        else if (pick < 85) push_text("ERROR\r\n");
        else if (pick < 95) break_keyword("OK\r\n");
        else push_measure();
      end
      ST_WAIT_HDR: begin
        if (pick < 75) push_text("+IPD,");
        else if (pick < 85) break_keyword("+IPD,");
        else if (pick < 92) push_measure();
        else push_noise($urandom_range(4, 1));
      end
      ST_CHANNEL: begin
        for (int i = 0; i < int'(pick % 4); i++) begin
          if ($urandom_range(3) == 0) push_byte(8'($urandom_range(255)));
          else push_byte(8'($urandom_range(CHAR_NINE, CHAR_ZERO)));
        end
        if (link_copy[GEN_COPY].state == ST_CHANNEL) push_byte(",");
      end
      ST_LENGTH: begin
        sel = $urandom_range(19);
        digits = "";
        if (sel < 10) digits = $sformatf("%0d", $urandom_range(60, 1));
        else if (sel < 13) digits = "";
        else if (sel == 13) digits = "0";
        else if (sel == 14) digits = "00";
        else if (sel < 17) digits = $sformatf("%0d", $urandom_range(99999, 1000));
        else if (sel == 17) digits = "9999";
        else push_noise($urandom_range(3, 1));
        push_text(digits);
        if (link_copy[GEN_COPY].state == ST_LENGTH) push_byte(":");
      end
      ST_PAYLOAD: begin
        // long announced payloads are cut short by a measurement event
        if (int'(g.len) > int'(g.count) + 70) begin
          push_measure();
        end else begin
          while (link_copy[GEN_COPY].state == ST_PAYLOAD) begin
            if ($urandom_range(99) == 0) push_measure();
            else push_byte(8'($urandom_range(255)));
          end
        end
      end
      ST_WAIT_PROMPT: begin
        if (pick < 80) push_text(">");
        else if (pick < 90) push_measure();
        else push_noise(1);
      end
      ST_WAIT_SENDOK: begin
        if (pick < 80) push_text("SEND OK\r\n");
        else if (pick < 95) break_keyword("SEND OK\r\n");
        else push_measure();
      end
      ST_WAIT_CONN: begin
        if (pick < 60) push_text("OK\r\n");
        else if (pick < 85) push_text("ERROR");
        else if (pick < 95) break_keyword("ERROR");
        else push_noise(2);
      end
      default: push_noise(1);
    endcase
  endtask

  // Fixed opening session: boot sequence, header field corner cases, events
  task automatic gen_directed();
    push_text("WIFI GOT IP\r\n");
    repeat (4) push_text("OK\r\n");
    // extreme channel bytes, a third character that is ignored
    push_text("+IPD,");
    push_byte(8'hFF);
    push_byte(8'h00);
    push_text("c,");
    // non-digit length counts as zero: one payload byte is still taken
    push_text("x:");
    push_byte(8'hA5);
    push_measure();
    push_text("OK\r\n");
    // fifth length digit is dropped, event leaves the payload early
    push_text("+IPD,7,98765:");
    push_measure();
    push_text("ERROR");
  endtask

  task automatic wait_drained();
    while (pending_requests.size() != 0 || req_ch.valid || predicted_replies.size() != 0)
      @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Request driver: predicts each accepted request, offers the next one
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        predicted_replies.push_back(advance_link(CHECK_COPY, op_t'(req_ch.opcode),
                                                 req_ch.rx_byte));
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_request = pending_requests.pop_front();
          req_ch.valid <= 1'b1;
          req_ch.opcode <= next_request.op;
          req_ch.rx_byte <= next_request.data;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Response monitor
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    link_rsp_t want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (predicted_replies.size() == 0) begin
          $display("%0t: response expected none, actual state %0d", $time,
                   rsp_ch.link_state);
          mismatches++;
        end else begin
          want = predicted_replies.pop_front();
          check_field("send_command", want.cmd, rsp_ch.send_command);
          check_field("channel_text", want.chan, rsp_ch.channel_text);
          check_field("channel_chars", want.nchan, rsp_ch.channel_chars);
          check_field("payload_length", want.len, rsp_ch.payload_length);
          check_field("payload_valid", want.pvalid, rsp_ch.payload_valid);
          check_field("payload_byte", want.pbyte, rsp_ch.payload_byte);
          check_field("payload_index", want.pidx, rsp_ch.payload_index);
          check_field("echo_byte", want.echo, rsp_ch.echo_byte);
          check_field("link_state", want.state, rsp_ch.link_state);
        end
      end
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, then three idling phases, each drained before the next
  // ---------------------------------------------------------------------------
  initial begin
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.opcode = OP_BYTE;
    req_ch.rx_byte = 8'h00;
    rsp_ch.ready = 1'b0;
    gen_count = 0;
    mismatches = 0;
    cycle_count = 0;
    send_idle_pct = 25;
    recv_idle_pct = 57;
    link_copy[GEN_COPY] = link_reset_value();
    link_copy[CHECK_COPY] = link_reset_value();

    gen_directed();
    while (gen_count < 230) gen_chunk();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    wait_drained();

    send_idle_pct = 57;
    recv_idle_pct = 25;
    while (gen_count < 460) gen_chunk();
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (gen_count < 690) gen_chunk();
    wait_drained();

    // extra wait so that stray responses show up before the verdict
    repeat (8) @(negedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
